FILE: rtl/core/rgb_to_hsv_converter_defines.svh
// Assertion macros shared by the converter RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HSV_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("hsv check failed");

// Next-cycle implication, disabled while reset is high.
`define HSV_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("hsv check failed");

`endif

FILE: rtl/core/hsv_pkg.sv
// Shared widths, constants and types for the RGB to HSV converter.
// No dependencies.
`timescale 1ns / 1ps
package hsv_pkg;

  localparam int CH_W    = 8;
  localparam int HUE_W   = 15;
  localparam int SAT_W   = 13;
  localparam int QUO_W   = 13;   // quotients reach 4096
  localparam int NUM_W   = 20;   // 255 * 4096 fits
  localparam int FRONT_STAGES = 2;

  localparam int HUE_SECTOR = 3840;  // 60 degrees in 1/64 degree
  localparam int HUE_FULL   = 23040;
  localparam int SAT_SHIFT  = 12;    // Q1.12

  localparam int HSV_DIV_STEPS = 4;  // quotient bits per divider stage

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Fields that ride alongside the dividers.
  typedef struct packed {
    logic [CH_W-1:0] value;
    sector_t         sector;
    logic            neg;
    logic            grey;
  } side_t;

endpackage

FILE: rtl/core/hsv_front.sv
// Front two pipeline stages: max/min, sector select, hue difference,
// then divider numerators and denominators. Depends on hsv_pkg.
`timescale 1ns / 1ps
module hsv_front import hsv_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] en,
  input  logic [CH_W-1:0]         red,
  input  logic [CH_W-1:0]         green,
  input  logic [CH_W-1:0]         blue,
  output side_t                   side,
  output logic [NUM_W-1:0]        num_s,
  output logic [NUM_W-1:0]        num_h,
  output logic [CH_W-1:0]         den_s,
  output logic [CH_W-1:0]         den_h
);

  logic [CH_W-1:0] mx, mn;
  logic signed [CH_W:0] diff, absd;
  side_t           s1_side_next;
  side_t           s1_side;
  logic [CH_W-1:0] s1_delta;
  logic [CH_W-1:0] s1_absdiff;
  logic [CH_W+3:0] x15;

  always_comb begin
    mx = (red > green) ? red : green;
    mn = (red < green) ? red : green;
    if (blue > mx) mx = blue;
    if (blue < mn) mn = blue;

    s1_side_next.value = mx;
    s1_side_next.grey  = (mx == mn);
    priority if (red == mx) begin
      s1_side_next.sector = SECT_RED;
      diff = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green == mx) begin
      s1_side_next.sector = SECT_GREEN;
      diff = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      s1_side_next.sector = SECT_BLUE;
      diff = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    s1_side_next.neg = diff[CH_W];
    absd = diff[CH_W] ? -diff : diff;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_side    <= s1_side_next;
      s1_delta   <= mx - mn;
      s1_absdiff <= absd[CH_W-1:0];
    end
  end

  // 3840 * d = (16 * d - d) << 8
  assign x15 = {s1_absdiff, 4'b0} - {4'b0, s1_absdiff};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side  <= s1_side;
      num_s <= {s1_delta, {SAT_SHIFT{1'b0}}};
      num_h <= {x15, 8'b0};
      den_s <= s1_side.value;
      den_h <= s1_delta;
    end
  end

endmodule

FILE: rtl/core/hsv_div.sv
// Pipelined restoring divider: STEPS quotient bits per register stage.
// Quotient must stay below 2**QUO_W. Depends on hsv_pkg.
`timescale 1ns / 1ps
module hsv_div import hsv_pkg::*; #(
  parameter int STEPS = HSV_DIV_STEPS,
  localparam int DIV_STAGES = (QUO_W + STEPS - 1) / STEPS
) (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [NUM_W-1:0]      num,
  input  logic [CH_W-1:0]       den,
  output logic [QUO_W-1:0]      quo
);

  // rem stays below den, so CH_W bits hold it
  logic [CH_W-1:0]  rem_q  [DIV_STAGES];
  logic [QUO_W-1:0] work_q [DIV_STAGES];
  logic [CH_W-1:0]  den_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [CH_W-1:0]  rem_in, rem_next;
    logic [QUO_W-1:0] work_in, work_next;
    logic [CH_W-1:0]  den_in;
    logic [CH_W:0]    t;
    logic [CH_W:0]    sub;

    if (s == 0) begin : g_first
      assign rem_in  = CH_W'(num[NUM_W-1:QUO_W]);
      assign work_in = num[QUO_W-1:0];
      assign den_in  = den;
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign work_in = work_q[s-1];
      assign den_in  = den_q[s-1];
    end

    always_comb begin
      rem_next  = rem_in;
      work_next = work_in;
      t   = '0;
      sub = '0;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < QUO_W) begin
          t   = {rem_next, work_next[QUO_W-1]};
          sub = t - {1'b0, den_in};
          if (t >= {1'b0, den_in}) begin
            rem_next  = sub[CH_W-1:0];
            work_next = {work_next[QUO_W-2:0], 1'b1};
          end else begin
            rem_next  = t[CH_W-1:0];
            work_next = {work_next[QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_q[s]  <= rem_next;
        work_q[s] <= work_next;
        den_q[s]  <= den_in;
      end
    end
  end

  assign quo = work_q[DIV_STAGES-1];

endmodule

FILE: rtl/core/hsv_back.sv
// Output stage: hue assembly from sector offset and quotient, wrap of
// negative hue, grey override, output register. Depends on hsv_pkg.
`timescale 1ns / 1ps
module hsv_back import hsv_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  side_t             side,
  input  logic [QUO_W-1:0]  quo_s,
  input  logic [QUO_W-1:0]  quo_h,
  output logic [HUE_W-1:0]  hue,
  output logic [SAT_W-1:0]  sat,
  output logic [CH_W-1:0]   value
);

  logic signed [HUE_W:0] off, qs, hs;
  logic [HUE_W-1:0]      hue_next;
  logic [SAT_W-1:0]      sat_next;

  always_comb begin
    unique case (side.sector)
      SECT_RED:   off = '0;
      SECT_GREEN: off = (HUE_W+1)'(2 * HUE_SECTOR);
      SECT_BLUE:  off = (HUE_W+1)'(4 * HUE_SECTOR);
      default:    off = '0;
    endcase
    qs = $signed({{(HUE_W+1-QUO_W){1'b0}}, quo_h});
    if (side.neg) qs = -qs;
    hs = off + qs;
    if (hs < 0) hs = hs + (HUE_W+1)'(HUE_FULL);
    hue_next = side.grey ? '0 : hs[HUE_W-1:0];
    sat_next = side.grey ? '0 : quo_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue   <= hue_next;
      sat   <= sat_next;
      value <= side.value;
    end
  end

endmodule

FILE: rtl/core/rgb_to_hsv_converter.sv
// RGB to HSV converter top level: pipeline control and stage wiring.
// Depends on hsv_pkg, hsv_front, hsv_div, hsv_back and the defines header.
//
// Usage:
//   Pixel channel: pix_valid / pix_stall with red_in, green_in, blue_in.
//   Result channel: hsv_valid / hsv_stall with hue_out, sat_out, value_out.
//   An item moves when valid is high and stall is low at a rising edge.
//   Throughput is one pixel per clock while hsv_stall is low. The stages
//   are two front stages, the divider stages and the output register.
//   The divider stage count sets the depth; two dividers (saturation
//   and hue) run side by side.
//   Each stage holds its item only while the stage after it is full and
//   blocked, so bubbles close up and pix_stall rises only when every stage
//   holds an item and hsv_stall is high. A stalled result stays on the
//   outputs unchanged.
//   Synchronous reset (rst) empties the pipeline; data is not reset.
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_defines.svh"
module rgb_to_hsv_converter import hsv_pkg::*; #(
  parameter int DIV_STEPS_PER_STAGE = HSV_DIV_STEPS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_valid,
  output logic             pix_stall,
  input  logic [CH_W-1:0]  red_in,
  input  logic [CH_W-1:0]  green_in,
  input  logic [CH_W-1:0]  blue_in,
  output logic             hsv_valid,
  input  logic             hsv_stall,
  output logic [HUE_W-1:0] hue_out,
  output logic [SAT_W-1:0] sat_out,
  output logic [CH_W-1:0]  value_out
);

  localparam int DIV_STAGES = (QUO_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
  localparam int NST        = FRONT_STAGES + DIV_STAGES + 1;

  logic [NST-1:0]   valid_q;
  logic [NST-1:0]   en;
  side_t            front_side;
  logic [NUM_W-1:0] num_s, num_h;
  logic [CH_W-1:0]  den_s, den_h;
  logic [QUO_W-1:0] quo_s, quo_h;
  side_t            side_q [DIV_STAGES];

  // a stage loads when empty or when its contents move on
  always_comb begin
    en[NST-1] = !valid_q[NST-1] || !hsv_stall;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= pix_valid;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  assign pix_stall = !en[0];
  assign hsv_valid = valid_q[NST-1];

  hsv_front u_front (
    .clk   (clk),
    .en    (en[FRONT_STAGES-1:0]),
    .red   (red_in),
    .green (green_in),
    .blue  (blue_in),
    .side  (front_side),
    .num_s (num_s),
    .num_h (num_h),
    .den_s (den_s),
    .den_h (den_h)
  );

  hsv_div #(.STEPS(DIV_STEPS_PER_STAGE)) u_div_sat (
    .clk (clk),
    .en  (en[FRONT_STAGES +: DIV_STAGES]),
    .num (num_s),
    .den (den_s),
    .quo (quo_s)
  );

  hsv_div #(.STEPS(DIV_STEPS_PER_STAGE)) u_div_hue (
    .clk (clk),
    .en  (en[FRONT_STAGES +: DIV_STAGES]),
    .num (num_h),
    .den (den_h),
    .quo (quo_h)
  );

  // sideband fields follow the divider stages
  for (genvar d = 0; d < DIV_STAGES; d++) begin : g_side
    if (d == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[FRONT_STAGES]) side_q[0] <= front_side;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[FRONT_STAGES + d]) side_q[d] <= side_q[d-1];
      end
    end
  end

  hsv_back u_back (
    .clk   (clk),
    .en    (en[NST-1]),
    .side  (side_q[DIV_STAGES-1]),
    .quo_s (quo_s),
    .quo_h (quo_h),
    .hue   (hue_out),
    .sat   (sat_out),
    .value (value_out)
  );

  `HSV_ASSERT_IMP(a_hue_range, clk, rst, hsv_valid, hue_out < HUE_W'(HUE_FULL))
  `HSV_ASSERT_IMP(a_sat_range, clk, rst, hsv_valid, sat_out <= SAT_W'(1 << SAT_SHIFT))
  `HSV_ASSERT_IMP(a_grey_hue, clk, rst, hsv_valid && (sat_out == '0), hue_out == '0)
  `HSV_ASSERT_IMP(a_stall_full, clk, rst, pix_stall, (&valid_q) && hsv_stall)

endmodule

FILE: test/hsv_result_checker.sv
// Checker for the RGB to HSV converter: predicts each pixel's HSV result and
// compares it with what the block returns. Depends on hsv_pkg.
`timescale 1ns / 1ps
module hsv_result_checker import hsv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_valid,
  input  logic             pix_stall,
  input  logic [CH_W-1:0]  red_in,
  input  logic [CH_W-1:0]  green_in,
  input  logic [CH_W-1:0]  blue_in,
  input  logic             hsv_valid,
  input  logic             hsv_stall,
  input  logic [HUE_W-1:0] hue_out,
  input  logic [SAT_W-1:0] sat_out,
  input  logic [CH_W-1:0]  value_out,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [CH_W-1:0]  value;
  } hsv_t;

  hsv_t hsv_expected_q[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic hsv_t predict_hsv(input logic [CH_W-1:0] r, g, b);
    hsv_t res;
    int   rv, gv, bv, mx, mn, delta, offset, diff, h, s;
    rv = int'(r);
    gv = int'(g);
    bv = int'(b);
    mx = (rv > gv) ? rv : gv;
    mn = (rv < gv) ? rv : gv;
    if (bv > mx) mx = bv;
    if (bv < mn) mn = bv;
    res.value = CH_W'(mx);
    if (mx == mn) begin
      res.hue = '0;
      res.sat = '0;
      return res;
    end
    delta = mx - mn;
    s = (delta * (1 << SAT_SHIFT)) / mx;
    res.sat = SAT_W'(s);
    // first channel equal to max picks the sector
    if (rv == mx) begin
      offset = 0;
      diff   = gv - bv;
    end else if (gv == mx) begin
      offset = 2 * HUE_SECTOR;
      diff   = bv - rv;
    end else begin
      offset = 4 * HUE_SECTOR;
      diff   = rv - gv;
    end
    // signed int division truncates toward zero
    h = offset + (HUE_SECTOR * diff) / delta;
    if (h < 0) h += HUE_FULL;
    res.hue = HUE_W'(h);
    return res;
  endfunction

  always @(posedge clk) begin
    hsv_t got, want;
    int   errs;
    errs = 0;
    if (rst) begin
      hsv_expected_q.delete();
      outstanding <= 0;
    end else begin
      if (hsv_valid && !hsv_stall) begin
        got.hue   = hue_out;
        got.sat   = sat_out;
        got.value = value_out;
        if (hsv_expected_q.size() == 0) begin
          $display("%0t: unexpected item hue=%0d sat=%0d value=%0d",
                   $time, got.hue, got.sat, got.value);
          errs++;
        end else begin
          want = hsv_expected_q.pop_front();
          if (got.hue !== want.hue) begin
            $display("%0t: hue_out expected %0d actual %0d", $time, want.hue, got.hue);
            errs++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: sat_out expected %0d actual %0d", $time, want.sat, got.sat);
            errs++;
          end
          if (got.value !== want.value) begin
            $display("%0t: value_out expected %0d actual %0d",
                     $time, want.value, got.value);
            errs++;
          end
        end
      end
      if (pix_valid && !pix_stall)
        hsv_expected_q.push_back(predict_hsv(red_in, green_in, blue_in));
      outstanding <= hsv_expected_q.size();
    end
    if (errs != 0) fail_count <= fail_count + errs;
  end

endmodule

FILE: test/rgb_to_hsv_converter_test.sv
// Testbench top for the RGB to HSV converter: clock, reset, pixel stimulus,
// result backpressure and verdict. Depends on hsv_pkg, hsv_result_checker, the RTL.
`timescale 1ns / 1ps
module rgb_to_hsv_converter_test;
  import hsv_pkg::*;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            pix_valid = 1'b0;
  logic            pix_stall;
  logic [CH_W-1:0] red_in    = '0;
  logic [CH_W-1:0] green_in  = '0;
  logic [CH_W-1:0] blue_in   = '0;
  logic            hsv_valid;
  logic            hsv_stall = 1'b0;
  logic [HUE_W-1:0] hue_out;
  logic [SAT_W-1:0] sat_out;
  logic [CH_W-1:0]  value_out;

  int   fail_count;
  int   outstanding;
  int   tx_pct    = 0;
  int   rx_pct    = 0;
  logic hold_req  = 1'b0;
  int   hold_left = 0;

  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 200;

  rgb_to_hsv_converter uut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .hsv_valid(hsv_valid), .hsv_stall(hsv_stall),
    .hue_out(hue_out), .sat_out(sat_out), .value_out(value_out)
  );

  hsv_result_checker chk (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .hsv_valid(hsv_valid), .hsv_stall(hsv_stall),
    .hue_out(hue_out), .sat_out(sat_out), .value_out(value_out),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // result side backpressure; a hold request stalls until hold_left runs out
  always @(posedge clk) begin
    if (rst) begin
      hsv_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      hsv_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left != 0) begin
      hsv_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      hsv_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
    int idle;
    idle = 0;
    while ($urandom_range(99) < tx_pct && idle < 20) idle++;
    if (idle > 0) begin
      pix_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    red_in    <= r;
    green_in  <= g;
    blue_in   <= b;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  task automatic send_random_pixel();
    logic [CH_W-1:0] r, g, b, v;
    logic [CH_W-1:0] edge_vals[4];
    int              kind;
    edge_vals = '{8'd0, 8'd1, 8'd254, 8'd255};
    kind = $urandom_range(99);
    r = CH_W'($urandom);
    g = CH_W'($urandom);
    b = CH_W'($urandom);
    v = CH_W'($urandom);
    if (kind < 60) begin
      // fully random
    end else if (kind < 70) begin
      r = v; g = v; b = v;
    end else if (kind < 85) begin
      case ($urandom_range(2))
        0: begin r = v; g = v; end
        1: begin g = v; b = v; end
        default: begin r = v; b = v; end
      endcase
    end else begin
      r = edge_vals[2'($urandom_range(3))];
      g = edge_vals[2'($urandom_range(3))];
      b = edge_vals[2'($urandom_range(3))];
    end
    send_pixel(r, g, b);
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [23:0] corner_px[];
    int          tx_modes[4];
    int          rx_modes[4];
    // grey, primaries, ties for max, hue wrap below zero, tiny deltas
    corner_px = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000,
                  24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
                  24'hFF0001, 24'h010000, 24'h000100, 24'h000001, 24'hFFFE00,
                  24'h01FF00, 24'h7F80FF, 24'hFEFFFF, 24'hFFFEFF, 24'hFFFFFE,
                  24'h0001FF, 24'hFF01FE};
    tx_modes = '{0, 58, 0, 37};
    rx_modes = '{0, 0, 58, 37};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_px[i])
      send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);

    for (int p = 0; p < 4; p++) begin
      drain();
      tx_pct = tx_modes[p];
      rx_pct <= rx_modes[p];
      repeat (PHASE_ITEMS) send_random_pixel();
    end

    // long receiver hold while pixels keep coming: pipeline fills, input stalls
    drain();
    tx_pct = 0;
    rx_pct <= 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (40) send_random_pixel();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
